// File: rtl/core/ehi_pkg.sv
// shared types and constants of the extendible hash index
// no dependencies; every other file but ehi_ram imports this package
package ehi_pkg;

    // fixed widths of the word fields
    localparam int KEY_BITS       = 32;
    localparam int VALUE_BITS     = 32;
    localparam int DEPTH_OUT_BITS = 4;
    localparam int COUNT_OUT_BITS = 9;

    // entries of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // result status codes
    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_DROPPED = 1'b1;

    // item kind codes on the request channel
    localparam logic KIND_INSERT = 1'b0;

    typedef enum logic {
        OP_INSERT,
        OP_LOOKUP
    } op_t;

    // classified request word held in the queue
    typedef struct packed {
        op_t                   op;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } item_t;

    // back-end sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DIR,
        S_META,
        S_LSCAN,
        S_DBL,
        S_RESTART,
        S_SPLIT_DIR,
        S_MOVE,
        S_META_B,
        S_META_NB
    } state_t;

endpackage

// File: rtl/core/ehi_if.sv
// request and result channel interfaces (valid/ready)
// depends on ehi_pkg for field widths
interface ehi_req_if;
    import ehi_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic signed [KEY_BITS-1:0]    key;
    logic signed [VALUE_BITS-1:0]  value;

    modport source (output valid, output kind, output key, output value, input ready);
    modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

interface ehi_rsp_if;
    import ehi_pkg::*;

    logic                            valid;
    logic                            ready;
    logic                            found;
    logic signed [VALUE_BITS-1:0]    found_value;
    logic                            status;
    logic [DEPTH_OUT_BITS-1:0]       global_depth;
    logic [COUNT_OUT_BITS-1:0]       bucket_count;

    modport source (output valid, output found, output found_value, output status,
                    output global_depth, output bucket_count, input ready);
    modport sink   (input valid, input found, input found_value, input status,
                    input global_depth, input bucket_count, output ready);
endinterface

// File: rtl/core/extendible_hash_index.sv
// extendible hash index top level: front queue plus back-end sequencer
// depends on ehi_pkg, ehi_if, ehi_front, ehi_back
// an insert that fits, a dropped insert and an empty-bucket lookup give their result once the
// bucket metadata is read; a lookup then scans its bucket (one slot read per cycle)
// a directory doubling walks the directory, and a split walks it and moves every slot of the
// full bucket, before the insert retries; the single slot port and the directory walk set that cost
// one word in the back end at a time, the next is taken the cycle after the result
// leaves; reset is asynchronous, active low, no clearing pass
module extendible_hash_index #(
    parameter int MAX_DEPTH    = 8,
    parameter int BUCKET_SLOTS = 4,
    parameter int DATA_BITS    = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    ehi_req_if.sink   req,
    ehi_rsp_if.source rsp
);
    import ehi_pkg::*;

    logic   q_valid;
    logic   q_pop;
    item_t  q_item;

    // accept and classify
    ehi_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .q_valid(q_valid),
        .q_item (q_item),
        .q_pop  (q_pop)
    );

    // carry out inserts and lookups
    ehi_back #(
        .MAX_DEPTH   (MAX_DEPTH),
        .BUCKET_SLOTS(BUCKET_SLOTS),
        .DATA_BITS   (DATA_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_valid(q_valid),
        .q_item (q_item),
        .q_pop  (q_pop),
        .rsp    (rsp)
    );
endmodule

// File: rtl/core/ehi_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module ehi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: rtl/core/ehi_front.sv
// front end: accepts request words, classifies them, queues them for the back end
// depends on ehi_pkg and ehi_req_if
module ehi_front (
    input  logic             clk,
    input  logic             rst_n,
    ehi_req_if.sink          req,
    output logic             q_valid,
    output ehi_pkg::item_t   q_item,
    input  logic             q_pop
);
    import ehi_pkg::*;

    localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    item_t            entry_reg [QUEUE_DEPTH];
    logic [QPW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg, count_next;
    logic             push;
    item_t            incoming;

    // classify the word
    always_comb
    begin
        incoming.op    = (req.kind == KIND_INSERT) ? OP_INSERT : OP_LOOKUP;
        incoming.key   = req.key;
        incoming.value = req.value;
    end

    assign req.ready = (count_reg != QCW'(QUEUE_DEPTH));
    assign push      = req.valid && req.ready;
    assign q_valid   = (count_reg != '0);
    assign q_item    = entry_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= incoming;
        end
    end
endmodule

// File: rtl/core/ehi_back.sv
// back end: directory, bucket and slot memories and the insert/lookup sequencer
// depends on ehi_pkg, ehi_rsp_if and ehi_ram
module ehi_back #(
    parameter int MAX_DEPTH    = 8,
    parameter int BUCKET_SLOTS = 4,
    parameter int DATA_BITS    = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  ehi_pkg::item_t   q_item,
    output logic             q_pop,
    ehi_rsp_if.source        rsp
);
    import ehi_pkg::*;

    localparam int KW       = (DATA_BITS < KEY_BITS) ? DATA_BITS : KEY_BITS;
    localparam int DIR_SIZE = 1 << MAX_DEPTH;
    localparam int DW       = $clog2(MAX_DEPTH + 1);
    localparam int FW       = $clog2(BUCKET_SLOTS + 1);
    localparam int SAW      = $clog2(DIR_SIZE * BUCKET_SLOTS);
    localparam int CW       = MAX_DEPTH + 1;
    localparam int MW       = DW + FW;
    localparam int SW       = 2 * KW;

    // low index bits of a stored key
    function automatic logic [MAX_DEPTH-1:0] low_bits(input logic [KW-1:0] k);
        logic [KEY_BITS-1:0] t;
        t = KEY_BITS'(k);
        return t[MAX_DEPTH-1:0];
    endfunction

    function automatic logic [MAX_DEPTH-1:0] dmask(input logic [DW-1:0] d);
        return ~({MAX_DEPTH{1'b1}} << d);
    endfunction

    function automatic logic [SAW-1:0] slot_addr(input logic [MAX_DEPTH-1:0] b,
                                                 input logic [FW-1:0] j);
        return SAW'(SAW'(b) * SAW'(BUCKET_SLOTS) + SAW'(j));
    endfunction

    state_t                 state_reg, state_next;
    logic [DW-1:0]          depth_reg, depth_next;
    logic [CW-1:0]          used_reg, used_next;
    logic [1:0]             dir_init_reg, dir_init_next;
    logic [1:0]             meta_init_reg, meta_init_next;
    op_t                    op_reg, op_next;
    logic [KW-1:0]          key_reg, key_next;
    logic [KW-1:0]          val_reg, val_next;
    logic [MAX_DEPTH-1:0]   idx_reg, idx_next;
    logic [MAX_DEPTH-1:0]   b_reg, b_next;
    logic [MAX_DEPTH-1:0]   nb_reg, nb_next;
    logic [MAX_DEPTH-1:0]   pat_reg, pat_next;
    logic [DW-1:0]          ld_reg, ld_next;
    logic [FW-1:0]          fill_reg, fill_next;
    logic [CW-1:0]          j_reg, j_next;
    logic [FW-1:0]          s_reg, s_next;
    logic [FW-1:0]          cb_reg, cb_next;
    logic [FW-1:0]          cn_reg, cn_next;
    logic [MAX_DEPTH-1:0]   dir_ra_reg;
    logic [MAX_DEPTH-1:0]   meta_ra_reg;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_found_reg, out_found_next;
    logic [KW-1:0]          out_val_reg, out_val_next;
    logic                   out_status_reg, out_status_next;

    // memory ports
    logic                   dir_we, meta_we, slot_we;
    logic [MAX_DEPTH-1:0]   dir_wa, dir_ra, meta_wa, meta_ra;
    logic [MAX_DEPTH-1:0]   dir_wd, dir_rdata;
    logic [MW-1:0]          meta_wd, meta_rdata;
    logic [SAW-1:0]         slot_wa, slot_ra;
    logic [SW-1:0]          slot_wd, slot_rdata;

    // derived read values
    logic [MAX_DEPTH-1:0]   dir_q;
    logic [DW-1:0]          ld_q;
    logic [FW-1:0]          fill_q;
    logic [KW-1:0]          rd_key, rd_val;
    logic [CW-1:0]          dir_size;
    logic [CW-1:0]          dbl_sum;
    logic [MAX_DEPTH-1:0]   mb;
    logic [MAX_DEPTH-1:0]   new_idx;
    logic [MAX_DEPTH-1:0]   in_idx;
    logic [KW-1:0]          in_key;
    logic [DW-1:0]          nld;
    logic                   ins_fits, at_local, at_limit, scan_hit, scan_more, dir_more;

    ehi_ram #(.WIDTH(MAX_DEPTH), .DEPTH(DIR_SIZE)) u_dir (
        .clk(clk), .we(dir_we), .waddr(dir_wa), .wdata(dir_wd),
        .raddr(dir_ra), .rdata(dir_rdata)
    );

    ehi_ram #(.WIDTH(MW), .DEPTH(DIR_SIZE)) u_meta (
        .clk(clk), .we(meta_we), .waddr(meta_wa), .wdata(meta_wd),
        .raddr(meta_ra), .rdata(meta_rdata)
    );

    ehi_ram #(.WIDTH(SW), .DEPTH(DIR_SIZE * BUCKET_SLOTS)) u_slot (
        .clk(clk), .we(slot_we), .waddr(slot_wa), .wdata(slot_wd),
        .raddr(slot_ra), .rdata(slot_rdata)
    );

    // reset contents of entries 0 and 1 until they are first written
    always_comb
    begin
        if (dir_ra_reg[MAX_DEPTH-1:1] == '0 && !dir_init_reg[dir_ra_reg[0]])
        begin
            dir_q = dir_ra_reg;
        end
        else
        begin
            dir_q = dir_rdata;
        end
        if (meta_ra_reg[MAX_DEPTH-1:1] == '0 && !meta_init_reg[meta_ra_reg[0]])
        begin
            ld_q   = DW'(1);
            fill_q = '0;
        end
        else
        begin
            ld_q   = meta_rdata[MW-1:FW];
            fill_q = meta_rdata[FW-1:0];
        end
    end

    // common conditions
    assign rd_key    = slot_rdata[SW-1:KW];
    assign rd_val    = slot_rdata[KW-1:0];
    assign dir_size  = CW'(1) << depth_reg;
    assign dbl_sum   = dir_size + j_reg;
    assign mb        = dmask(ld_reg);
    assign nld       = ld_q + 1'b1;
    assign new_idx   = low_bits(key_reg) & dmask(depth_reg);
    assign in_key    = q_item.key[KW-1:0];
    assign in_idx    = low_bits(in_key) & dmask(depth_reg);
    assign ins_fits  = fill_q < FW'(BUCKET_SLOTS);
    assign at_local  = ld_q >= depth_reg;
    assign at_limit  = depth_reg >= DW'(MAX_DEPTH);
    assign scan_hit  = rd_key == key_reg;
    assign scan_more = ({1'b0, s_reg} + 1'b1) < {1'b0, fill_reg};
    assign dir_more  = (j_reg + 1'b1) < dir_size;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && !out_valid_reg)
                begin
                    state_next = S_DIR;
                end
            end
            S_DIR:
            begin
                state_next = S_META;
            end
            S_META:
            begin
                if (op_reg == OP_LOOKUP)
                begin
                    state_next = (fill_q == '0) ? S_IDLE : S_LSCAN;
                end
                else if (ins_fits)
                begin
                    state_next = S_IDLE;
                end
                else if (at_local)
                begin
                    state_next = at_limit ? S_IDLE : S_DBL;
                end
                else
                begin
                    state_next = S_SPLIT_DIR;
                end
            end
            S_LSCAN:
            begin
                if (scan_hit || !scan_more)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DBL:
            begin
                if (!dir_more)
                begin
                    state_next = S_RESTART;
                end
            end
            S_RESTART:
            begin
                state_next = S_DIR;
            end
            S_SPLIT_DIR:
            begin
                if (!dir_more)
                begin
                    state_next = S_MOVE;
                end
            end
            S_MOVE:
            begin
                if (!scan_more)
                begin
                    state_next = S_META_B;
                end
            end
            S_META_B:
            begin
                state_next = S_META_NB;
            end
            S_META_NB:
            begin
                state_next = S_RESTART;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        q_pop           = 1'b0;
        depth_next      = depth_reg;
        used_next       = used_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        idx_next        = idx_reg;
        b_next          = b_reg;
        nb_next         = nb_reg;
        pat_next        = pat_reg;
        ld_next         = ld_reg;
        fill_next       = fill_reg;
        j_next          = j_reg;
        s_next          = s_reg;
        cb_next         = cb_reg;
        cn_next         = cn_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_found_next  = out_found_reg;
        out_val_next    = out_val_reg;
        out_status_next = out_status_reg;
        dir_we          = 1'b0;
        dir_wa          = '0;
        dir_wd          = '0;
        dir_ra          = '0;
        meta_we         = 1'b0;
        meta_wa         = '0;
        meta_wd         = '0;
        meta_ra         = '0;
        slot_we         = 1'b0;
        slot_wa         = '0;
        slot_wd         = '0;
        slot_ra         = '0;
        case (state_reg)
            S_IDLE:
            begin
                // take a word and look up its directory entry
                if (q_valid && !out_valid_reg)
                begin
                    q_pop    = 1'b1;
                    op_next  = q_item.op;
                    key_next = in_key;
                    val_next = q_item.value[KW-1:0];
                    idx_next = in_idx;
                    dir_ra   = in_idx;
                end
            end
            S_DIR:
            begin
                b_next  = dir_q;
                meta_ra = dir_q;
            end
            S_META:
            begin
                ld_next   = ld_q;
                fill_next = fill_q;
                s_next    = '0;
                j_next    = '0;
                if (op_reg == OP_LOOKUP)
                begin
                    slot_ra = slot_addr(b_reg, '0);
                    if (fill_q == '0)
                    begin
                        out_valid_next  = 1'b1;
                        out_found_next  = 1'b0;
                        out_val_next    = '0;
                        out_status_next = STATUS_DONE;
                    end
                end
                else if (ins_fits)
                begin
                    // append to the bucket
                    slot_we         = 1'b1;
                    slot_wa         = slot_addr(b_reg, fill_q);
                    slot_wd         = {key_reg, val_reg};
                    meta_we         = 1'b1;
                    meta_wa         = b_reg;
                    meta_wd         = {ld_q, fill_q + 1'b1};
                    out_valid_next  = 1'b1;
                    out_found_next  = 1'b0;
                    out_val_next    = '0;
                    out_status_next = STATUS_DONE;
                end
                else if (at_local)
                begin
                    if (at_limit)
                    begin
                        out_valid_next  = 1'b1;
                        out_found_next  = 1'b0;
                        out_val_next    = '0;
                        out_status_next = STATUS_DROPPED;
                    end
                    else
                    begin
                        dir_ra = '0;
                    end
                end
                else
                begin
                    // open the sibling bucket
                    ld_next   = nld;
                    nb_next   = used_reg[MAX_DEPTH-1:0];
                    used_next = used_reg + 1'b1;
                    pat_next  = (idx_reg & dmask(nld))
                                ^ (MAX_DEPTH'(1) << (nld - 1'b1));
                    dir_ra    = '0;
                end
            end
            S_LSCAN:
            begin
                if (scan_hit)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = 1'b1;
                    out_val_next    = rd_val;
                    out_status_next = STATUS_DONE;
                end
                else if (scan_more)
                begin
                    s_next  = s_reg + 1'b1;
                    slot_ra = slot_addr(b_reg, s_reg + 1'b1);
                end
                else
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = 1'b0;
                    out_val_next    = '0;
                    out_status_next = STATUS_DONE;
                end
            end
            S_DBL:
            begin
                // copy the lower half of the directory upward
                dir_we = 1'b1;
                dir_wa = dbl_sum[MAX_DEPTH-1:0];
                dir_wd = dir_q;
                if (dir_more)
                begin
                    j_next = j_reg + 1'b1;
                    dir_ra = j_next[MAX_DEPTH-1:0];
                end
                else
                begin
                    depth_next = depth_reg + 1'b1;
                end
            end
            S_RESTART:
            begin
                idx_next = new_idx;
                dir_ra   = new_idx;
            end
            S_SPLIT_DIR:
            begin
                // repoint entries of the new pattern to the sibling
                if (dir_q == b_reg && (j_reg[MAX_DEPTH-1:0] & mb) == pat_reg)
                begin
                    dir_we = 1'b1;
                    dir_wa = j_reg[MAX_DEPTH-1:0];
                    dir_wd = nb_reg;
                end
                if (dir_more)
                begin
                    j_next = j_reg + 1'b1;
                    dir_ra = j_next[MAX_DEPTH-1:0];
                end
                else
                begin
                    s_next  = '0;
                    cb_next = '0;
                    cn_next = '0;
                    slot_ra = slot_addr(b_reg, '0);
                end
            end
            S_MOVE:
            begin
                // redistribute entries in order, in place for the old bucket
                slot_we = 1'b1;
                slot_wd = slot_rdata;
                if ((low_bits(rd_key) & mb) == pat_reg)
                begin
                    slot_wa = slot_addr(nb_reg, cn_reg);
                    cn_next = cn_reg + 1'b1;
                end
                else
                begin
                    slot_wa = slot_addr(b_reg, cb_reg);
                    cb_next = cb_reg + 1'b1;
                end
                if (scan_more)
                begin
                    s_next  = s_reg + 1'b1;
                    slot_ra = slot_addr(b_reg, s_reg + 1'b1);
                end
            end
            S_META_B:
            begin
                meta_we = 1'b1;
                meta_wa = b_reg;
                meta_wd = {ld_reg, cb_reg};
            end
            S_META_NB:
            begin
                meta_we = 1'b1;
                meta_wa = nb_reg;
                meta_wd = {ld_reg, cn_reg};
            end
            default:
            begin
            end
        endcase
    end

    // entries 0 and 1 leave their reset contents once written
    always_comb
    begin
        dir_init_next  = dir_init_reg;
        meta_init_next = meta_init_reg;
        if (dir_we && dir_wa[MAX_DEPTH-1:1] == '0)
        begin
            dir_init_next[dir_wa[0]] = 1'b1;
        end
        if (meta_we && meta_wa[MAX_DEPTH-1:1] == '0)
        begin
            meta_init_next[meta_wa[0]] = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= DW'(1);
            used_reg      <= CW'(2);
            dir_init_reg  <= '0;
            meta_init_reg <= '0;
            out_valid_reg <= 1'b0;
            dir_ra_reg    <= '0;
            meta_ra_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            used_reg      <= used_next;
            dir_init_reg  <= dir_init_next;
            meta_init_reg <= meta_init_next;
            out_valid_reg <= out_valid_next;
            dir_ra_reg    <= dir_ra;
            meta_ra_reg   <= meta_ra;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        idx_reg        <= idx_next;
        b_reg          <= b_next;
        nb_reg         <= nb_next;
        pat_reg        <= pat_next;
        ld_reg         <= ld_next;
        fill_reg       <= fill_next;
        j_reg          <= j_next;
        s_reg          <= s_next;
        cb_reg         <= cb_next;
        cn_reg         <= cn_next;
        out_found_reg  <= out_found_next;
        out_val_reg    <= out_val_next;
        out_status_reg <= out_status_next;
    end

    // result word
    assign rsp.valid        = out_valid_reg;
    assign rsp.found        = out_found_reg;
    assign rsp.found_value  = VALUE_BITS'(out_val_reg);
    assign rsp.status       = out_status_reg;
    assign rsp.global_depth = DEPTH_OUT_BITS'(depth_reg);
    assign rsp.bucket_count = COUNT_OUT_BITS'(used_reg);

    // global depth stays in range
    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg >= DW'(1) && depth_reg <= DW'(MAX_DEPTH))
        else $error("global depth out of range");

    // never more buckets than directory entries
    a_buckets_fit: assert property (@(posedge clk) disable iff (!rst_n)
        (CW + 1)'(used_reg) <= ((CW + 1)'(1) << depth_reg))
        else $error("bucket count exceeds directory size");

    // a dropped insert only happens at the depth limit
    a_drop_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg == STATUS_DROPPED |-> depth_reg == DW'(MAX_DEPTH))
        else $error("insert dropped below depth limit");

    // results come only from bucket inspection or the lookup scan
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_META || $past(state_reg) == S_LSCAN)
        else $error("result raised from unexpected state");

    // no new word while a result is pending
    a_pop_gate: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !out_valid_reg && state_reg == S_IDLE)
        else $error("word taken while result pending");
endmodule
